### sv/gsm7_septet_unpack_to_utf8_assert.svh
// Assertion macros for the GSM 7-bit unpacker.
// Each macro expects clk and rst_n in scope of the file that uses it.
`ifndef GSM7_SEPTET_UNPACK_TO_UTF8_ASSERT_SVH
`define GSM7_SEPTET_UNPACK_TO_UTF8_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define GSM7_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsm7 assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define GSM7_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsm7 assertion failed");

`endif

### sv/gsm7_pkg.sv
// Shared types, constants and the GSM default alphabet table for the unpacker.
// No dependencies.
`default_nettype none
package gsm7_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] LAST_PHASE = 3'd6;

    localparam logic [7:0] LEAD_C2 = 8'hC2;
    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_CE = 8'hCE;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_AT = 8'h40;

    // One decoded item: up to four UTF-8 bytes, sent from index 0 upward
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            msg_last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic [2:0] phase;
    } front_stat_t;

    // UTF-8 form of a septet; a nonzero upper byte means two bytes
    function automatic logic [15:0] septet_to_utf8(input logic [6:0] s);
        logic [15:0] u;
        begin
            case (s)
                7'd0:   u = {8'h00, CHAR_AT};
                7'd1:   u = {LEAD_C2, 8'hA3};
                7'd2:   u = 16'h0024;
                7'd3:   u = {LEAD_C2, 8'hA5};
                7'd4:   u = {LEAD_C3, 8'hA8};
                7'd5:   u = {LEAD_C3, 8'hA9};
                7'd6:   u = {LEAD_C3, 8'hB9};
                7'd7:   u = {LEAD_C3, 8'hAC};
                7'd8:   u = {LEAD_C3, 8'hB2};
                7'd9:   u = {LEAD_C3, 8'h87};
                7'd11:  u = {LEAD_C3, 8'h98};
                7'd12:  u = {LEAD_C3, 8'hB8};
                7'd14:  u = {LEAD_C3, 8'h85};
                7'd15:  u = {LEAD_C3, 8'hA5};
                7'd16:  u = {LEAD_CE, 8'h94};
                7'd17:  u = 16'h005F;
                7'd18:  u = {LEAD_CE, 8'hA6};
                7'd19:  u = {LEAD_CE, 8'h93};
                7'd20:  u = {LEAD_CE, 8'h9B};
                7'd21:  u = {LEAD_CE, 8'hA9};
                7'd22:  u = {LEAD_CE, 8'hA0};
                7'd23:  u = {LEAD_CE, 8'hA8};
                7'd24:  u = {LEAD_CE, 8'hA3};
                7'd25:  u = {LEAD_CE, 8'h98};
                7'd26:  u = {LEAD_CE, 8'h9E};
                7'd27:  u = {8'h00, CHAR_QMARK};
                7'd28:  u = {LEAD_C3, 8'h86};
                7'd29:  u = {LEAD_C3, 8'hA6};
                7'd30:  u = {LEAD_C3, 8'h9F};
                7'd31:  u = {LEAD_C3, 8'h89};
                7'd36:  u = {LEAD_C2, 8'hA4};
                7'd64:  u = {LEAD_C2, 8'hA1};
                7'd91:  u = {LEAD_C3, 8'h84};
                7'd92:  u = {LEAD_C3, 8'h96};
                7'd93:  u = {LEAD_C3, 8'h91};
                7'd94:  u = {LEAD_C3, 8'h9C};
                7'd95:  u = {LEAD_C2, 8'hA7};
                7'd96:  u = {LEAD_C2, 8'hBF};
                7'd123: u = {LEAD_C3, 8'hA4};
                7'd124: u = {LEAD_C3, 8'hB6};
                7'd125: u = {LEAD_C3, 8'hB1};
                7'd126: u = {LEAD_C3, 8'hBC};
                7'd127: u = {LEAD_C3, 8'hA0};
                default: u = {9'd0, s};
            endcase
            return u;
        end
    endfunction

endpackage
`default_nettype wire

### sv/gsm7_septet_unpack_to_utf8.sv
// GSM 7-bit unpacker: packed user-data bytes in, UTF-8 bytes out.
// The first byte of an item is offered once the item has passed through the queue
// slot and into the back end's current-item register. An item yields 1 to 4 UTF-8
// bytes; the output port carries one byte per cycle while text_ready is high. Input
// is taken every cycle while the two-entry queue has room.
// Reset (rst_n low, asynchronous) clears phase, carry, queue and output valid.
`default_nettype none
`include "gsm7_septet_unpack_to_utf8_assert.svh"
module gsm7_septet_unpack_to_utf8 (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] packed_byte,
    input  wire logic       message_last,
    output logic            text_valid,
    input  wire logic       text_ready,
    output logic [7:0]      text_byte,
    output logic            run_last,
    output logic            message_end
);
    import gsm7_pkg::*;

    qstat_t      qstat;
    entry_t      push_entry;
    entry_t      head;
    front_stat_t fstat;
    logic        push;
    logic        pop;

    gsm7_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .packed_byte  (packed_byte),
        .message_last (message_last),
        .qstat        (qstat),
        .push         (push),
        .push_entry   (push_entry),
        .fstat        (fstat)
    );

    gsm7_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    gsm7_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .run_last    (run_last),
        .message_end (message_end)
    );

    // Checks on phase tracking, queue flow and item framing
    `GSM7_ASSERT_NOW(a_phase_range, 1'b1, fstat.phase <= LAST_PHASE)
    `GSM7_ASSERT_NEXT(a_msg_clears_phase, byte_valid && byte_ready && message_last,
                      fstat.phase == 3'd0)
    `GSM7_ASSERT_NOW(a_pop_not_empty, pop, !qstat.empty)
    `GSM7_ASSERT_NOW(a_end_on_run_last, text_valid && message_end, run_last)

endmodule
`default_nettype wire

### sv/gsm7_front.sv
// Front end: accepts packed bytes, forms septets and translates them to UTF-8.
// Depends on gsm7_pkg.
`default_nettype none
module gsm7_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_ready,
    input  wire logic [7:0]            packed_byte,
    input  wire logic                  message_last,
    input  wire gsm7_pkg::qstat_t      qstat,
    output logic                       push,
    output gsm7_pkg::entry_t           push_entry,
    output gsm7_pkg::front_stat_t      fstat
);
    import gsm7_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [6:0]  carry_reg, carry_next;
    logic [6:0]  low_mask;
    logic [6:0]  septet;
    logic [7:0]  top_bits;
    logic [15:0] u1, u2;
    logic        has2;
    logic [1:0]  n;
    entry_t      e;

    assign byte_ready = !qstat.full;
    assign push       = byte_valid && byte_ready;
    assign fstat.phase = phase_reg;

    // Split the byte: low bits join the carry, top bits become the new carry
    always_comb
    begin
        low_mask = 7'h7F >> phase_reg;
        septet   = 7'((packed_byte[6:0] & low_mask) << phase_reg) | carry_reg;
        top_bits = packed_byte >> (3'd7 - phase_reg);
        has2     = (phase_reg == LAST_PHASE);
        u1       = septet_to_utf8(septet);
        u2       = septet_to_utf8(packed_byte[7:1]);
    end

    // Lay out the UTF-8 bytes of one or two septets
    always_comb
    begin
        e = '0;
        if (u1[15:8] != 8'h00)
        begin
            e.bytes[0] = u1[15:8];
            e.bytes[1] = u1[7:0];
            n = 2'd1;
        end
        else
        begin
            e.bytes[0] = u1[7:0];
            n = 2'd0;
        end
        if (has2)
        begin
            if (u2[15:8] != 8'h00)
            begin
                e.bytes[2'(n + 2'd1)] = u2[15:8];
                e.bytes[2'(n + 2'd2)] = u2[7:0];
                n = 2'(n + 2'd2);
            end
            else
            begin
                e.bytes[2'(n + 2'd1)] = u2[7:0];
                n = 2'(n + 2'd1);
            end
        end
        e.last_idx = n;
        e.msg_last = message_last;
        push_entry = e;
    end

    // Advance phase and carry; drop both after the seventh byte or message end
    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (push)
        begin
            if (has2 || message_last)
            begin
                phase_next = 3'd0;
                carry_next = 7'd0;
            end
            else
            begin
                phase_next = 3'(phase_reg + 3'd1);
                carry_next = top_bits[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            carry_reg <= 7'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule
`default_nettype wire

### sv/gsm7_queue.sv
// Short queue of decoded items between the front and back ends.
// Depends on gsm7_pkg.
`default_nettype none
module gsm7_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire gsm7_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output gsm7_pkg::entry_t       head,
    output gsm7_pkg::qstat_t       qstat
);
    import gsm7_pkg::*;

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold item payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

### sv/gsm7_back.sv
// Back end: takes decoded items from the queue and sends one UTF-8 byte per cycle
// while text_ready is high. Depends on gsm7_pkg.
`default_nettype none
module gsm7_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gsm7_pkg::entry_t  head,
    input  wire gsm7_pkg::qstat_t  qstat,
    output logic                   pop,
    output logic                   text_valid,
    input  wire logic              text_ready,
    output logic [7:0]             text_byte,
    output logic                   run_last,
    output logic                   message_end
);
    import gsm7_pkg::*;

    logic       valid_reg, valid_next;
    entry_t     cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       take, done;

    assign text_valid  = valid_reg;
    assign text_byte   = cur_reg.bytes[idx_reg];
    assign run_last    = (idx_reg == cur_reg.last_idx);
    assign message_end = run_last && cur_reg.msg_last;

    assign take = valid_reg && text_ready;
    assign done = take && run_last;
    assign pop  = (!valid_reg || done) && !qstat.empty;

    // Load the next item as the current one finishes, else step through bytes
    always_comb
    begin
        valid_next = valid_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            cur_next   = head;
            idx_next   = 2'd0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule
`default_nettype wire

### dv/gsm7_septet_unpack_to_utf8_tb.sv
// Self-checking bench for the GSM 7-bit unpacker: packed bytes in, UTF-8 bytes out.
// Depends on gsm7_pkg (lead-byte and character constants) and the RTL top level.
// Checks every output byte against an in-bench decoder under mixed idling.
module gsm7_septet_unpack_to_utf8_tb;
    import gsm7_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int CLK_PERIOD = 2 * CLK_HALF;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MAX_SEPTETS = 24;
    localparam logic [6:0] SEPT_FILL = 7'd0;
    localparam logic [6:0] SEPT_ESCAPE = 7'd27;
    localparam logic [6:0] SEPT_TOP = 7'd127;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } packed_item_t;

    typedef struct {
        logic [7:0] text;
        logic       run_end;
        logic       msg_end;
    } utf8_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    logic [7:0] packed_byte = 8'd0;
    logic       message_last = 1'b0;
    logic       text_valid;
    logic       text_ready = 1'b0;
    logic [7:0] text_byte;
    logic       run_last;
    logic       message_end;

    // Stimulus and expectation stores
    packed_item_t packed_pending[$];
    packed_item_t next_item;
    utf8_out_t    utf8_due[$];
    utf8_out_t    step_out[$];
    utf8_out_t    want;
    logic [6:0]   msg_sept[0:MAX_SEPTETS-1];

    // Decoder state, mirrors the block
    logic [6:0] dec_carry = 7'd0;
    logic [2:0] dec_phase = 3'd0;

    int tx_idle_pct = 21;
    int rx_idle_pct = 80;
    logic hold_go = 1'b0;
    logic hold_seen;
    int hold_cnt;

    int items_queued = 0;
    int items_accepted = 0;
    int bytes_checked = 0;
    int messages_closed = 0;
    int double_septets = 0;
    int input_stalls = 0;
    int mismatches = 0;

    gsm7_septet_unpack_to_utf8 DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .packed_byte  (packed_byte),
        .message_last (message_last),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .run_last     (run_last),
        .message_end  (message_end)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // GSM default alphabet to UTF-8; upper byte nonzero means two bytes
    function automatic logic [15:0] gsm_utf8(input logic [6:0] code);
        case (code)
            7'd0:    return {8'h00, CHAR_AT};
            7'd1:    return {LEAD_C2, 8'hA3};
            7'd2:    return 16'h0024;
            7'd3:    return {LEAD_C2, 8'hA5};
            7'd4:    return {LEAD_C3, 8'hA8};
            7'd5:    return {LEAD_C3, 8'hA9};
            7'd6:    return {LEAD_C3, 8'hB9};
            7'd7:    return {LEAD_C3, 8'hAC};
            7'd8:    return {LEAD_C3, 8'hB2};
            7'd9:    return {LEAD_C3, 8'h87};
            7'd11:   return {LEAD_C3, 8'h98};
            7'd12:   return {LEAD_C3, 8'hB8};
            7'd14:   return {LEAD_C3, 8'h85};
            7'd15:   return {LEAD_C3, 8'hA5};
            7'd16:   return {LEAD_CE, 8'h94};
            7'd17:   return 16'h005F;
            7'd18:   return {LEAD_CE, 8'hA6};
            7'd19:   return {LEAD_CE, 8'h93};
            7'd20:   return {LEAD_CE, 8'h9B};
            7'd21:   return {LEAD_CE, 8'hA9};
            7'd22:   return {LEAD_CE, 8'hA0};
            7'd23:   return {LEAD_CE, 8'hA8};
            7'd24:   return {LEAD_CE, 8'hA3};
            7'd25:   return {LEAD_CE, 8'h98};
            7'd26:   return {LEAD_CE, 8'h9E};
            7'd27:   return {8'h00, CHAR_QMARK};
            7'd28:   return {LEAD_C3, 8'h86};
            7'd29:   return {LEAD_C3, 8'hA6};
            7'd30:   return {LEAD_C3, 8'h9F};
            7'd31:   return {LEAD_C3, 8'h89};
            7'd36:   return {LEAD_C2, 8'hA4};
            7'd64:   return {LEAD_C2, 8'hA1};
            7'd91:   return {LEAD_C3, 8'h84};
            7'd92:   return {LEAD_C3, 8'h96};
            7'd93:   return {LEAD_C3, 8'h91};
            7'd94:   return {LEAD_C3, 8'h9C};
            7'd95:   return {LEAD_C2, 8'hA7};
            7'd96:   return {LEAD_C2, 8'hBF};
            7'd123:  return {LEAD_C3, 8'hA4};
            7'd124:  return {LEAD_C3, 8'hB6};
            7'd125:  return {LEAD_C3, 8'hB1};
            7'd126:  return {LEAD_C3, 8'hBC};
            7'd127:  return {LEAD_C3, 8'hA0};
            default: return {9'd0, code};
        endcase
    endfunction

    task automatic add_septet(input logic [6:0] code);
        logic [15:0] u;
        u = gsm_utf8(code);
        if (u[15:8] != 8'h00)
            step_out.push_back(utf8_out_t'{u[15:8], 1'b0, 1'b0});
        step_out.push_back(utf8_out_t'{u[7:0], 1'b0, 1'b0});
    endtask

    // Work out the UTF-8 bytes one accepted item yields and queue them
    task automatic decode_byte(input logic [7:0] b, input logic is_last);
        logic [2:0]  p;
        logic [15:0] low_part;
        logic [6:0]  septet;
        logic [6:0]  top;
        p = dec_phase;
        low_part = ({8'd0, b} & ((16'd1 << (7 - p)) - 16'd1)) << p;
        septet = low_part[6:0] | dec_carry;
        top = 7'({8'd0, b} >> (7 - p));
        step_out.delete();
        add_septet(septet);
        if (p == LAST_PHASE)
        begin
            add_septet(top);
            double_septets++;
            dec_carry = 7'd0;
            dec_phase = 3'd0;
        end
        else
        begin
            dec_carry = top;
            dec_phase = p + 3'd1;
        end
        step_out[step_out.size() - 1].run_end = 1'b1;
        if (is_last)
        begin
            step_out[step_out.size() - 1].msg_end = 1'b1;
            dec_carry = 7'd0;
            dec_phase = 3'd0;
            messages_closed++;
        end
        foreach (step_out[i])
            utf8_due.push_back(step_out[i]);
    endtask

    task automatic push_item(input logic [7:0] data, input logic is_last);
        packed_pending.push_back(packed_item_t'{data, is_last});
        items_queued++;
    endtask

    // Pack msg_sept[0..n-1] into bytes; mark the final one unless cut
    task automatic queue_message(input int n, input bit with_last);
        logic [7:0] acc;
        int nbytes;
        int j;
        nbytes = (7 * n + 7) / 8;
        for (int k = 0; k < nbytes; k++)
        begin
            for (int bi = 0; bi < 8; bi++)
            begin
                j = 8 * k + bi;
                acc[bi] = (j / 7 < n) ? msg_sept[j / 7][j % 7] : 1'b0;
            end
            push_item(acc, with_last && (k == nbytes - 1));
        end
    endtask

    // Mostly well-formed messages, some cut short, the rest raw noise
    task automatic queue_random_traffic(input int count);
        int goal;
        int pick;
        int n;
        goal = items_queued + count;
        while (items_queued < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(7))
                        0: msg_sept[i] = SEPT_ESCAPE;
                        1: msg_sept[i] = SEPT_FILL;
                        default: msg_sept[i] = 7'($urandom_range(127));
                    endcase
                end
                queue_message(n, pick < 70);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_item(8'($urandom_range(255)), $urandom_range(7) == 0);
            end
        end
    endtask

    // Hold until everything offered has come back out
    task automatic wait_drained();
        while (packed_pending.size() != 0 || byte_valid || utf8_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Driver: present queued items, idle at random, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            packed_byte <= 8'd0;
            message_last <= 1'b0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                decode_byte(packed_byte, message_last);
                items_accepted++;
            end
            if (byte_valid && !byte_ready)
                input_stalls++;
            if (!byte_valid || byte_ready)
            begin
                if (packed_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_item = packed_pending.pop_front();
                    byte_valid <= 1'b1;
                    packed_byte <= next_item.data;
                    message_last <= next_item.is_last;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ready <= 1'b0;
            hold_seen <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_cnt <= HOLD_CYCLES;
            text_ready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            text_ready <= 1'b0;
        end
        else
        begin
            text_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: compare each accepted output byte with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && text_valid && text_ready)
        begin
            bytes_checked++;
            if (utf8_due.size() == 0)
            begin
                $display("%0t: unexpected output: expected nothing, got byte %h run_last %b message_end %b",
                         $time, text_byte, run_last, message_end);
                mismatches++;
            end
            else
            begin
                want = utf8_due.pop_front();
                if (text_byte !== want.text || run_last !== want.run_end
                    || message_end !== want.msg_end)
                begin
                    $display("%0t: mismatch: expected byte %h run_last %b message_end %b, got byte %h run_last %b message_end %b",
                             $time, want.text, want.run_end, want.msg_end,
                             text_byte, run_last, message_end);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d output bytes still due", utf8_due.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: escape, top code, all lead bytes, a pass-through letter,
        // and a full seventh byte carrying a second septet
        msg_sept[0] = SEPT_FILL;
        msg_sept[1] = SEPT_ESCAPE;
        msg_sept[2] = SEPT_TOP;
        msg_sept[3] = 7'd64;
        msg_sept[4] = 7'd36;
        msg_sept[5] = 7'd1;
        msg_sept[6] = 7'd16;
        msg_sept[7] = 7'd65;
        queue_message(8, 1'b1);
        // Single-byte messages at both extremes of the field
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b1);
        // Seven septets: the seventh byte ends in fill bits, emitted as '@'
        for (int i = 0; i < 7; i++)
            msg_sept[i] = (i == 0) ? SEPT_ESCAPE : 7'(7'd90 + i);
        queue_message(7, 1'b1);
        // All ones: every byte decodes to the top code, last byte yields four
        for (int i = 0; i < 7; i++)
            push_item(8'hFF, i == 6);
        // Message end in mid-phase must clear carry and phase
        msg_sept[0] = 7'd65;
        msg_sept[1] = 7'd28;
        msg_sept[2] = 7'd96;
        queue_message(3, 1'b1);
        wait_drained();

        // Slow receiver first, then the sides swapped for a slow sender
        queue_random_traffic(132);
        wait_drained();
        tx_idle_pct = 80;
        rx_idle_pct = 21;
        queue_random_traffic(132);
        wait_drained();

        // No idling; stall the receiver first so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go <= ~hold_go;
        queue_random_traffic(40);
        wait_drained();
        queue_random_traffic(92);
        wait_drained();

        $display("covered %0d input items, %0d UTF-8 bytes checked, %0d messages closed",
                 items_accepted, bytes_checked, messages_closed);
        $display("%0d seventh-byte double septets, %0d cycles with input held off by the block",
                 double_septets, input_stalls);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
